// ----- src/ipid_pkg.sv -----
// Shared types and constants for the incremental PID controller.
package ipid_pkg;

  localparam int SAMPLE_W = 24;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int GAIN_W   = 32;
  localparam int LIM_W    = 31;
  localparam int DRIVE_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Operand widths of the three gain products and of their exact sum.
  localparam int OP_P_W   = ERR_W + 1;
  localparam int OP_D_W   = ERR_W + 2;
  localparam int PROD_P_W = GAIN_W + OP_P_W;
  localparam int PROD_I_W = GAIN_W + ERR_W;
  localparam int PROD_D_W = GAIN_W + OP_D_W;
  localparam int SUM_W    = PROD_D_W + 3;
  // Width after the fractional shift, with room to add the accumulator.
  localparam int TOT_W    = SUM_W - FRAC_W + 1;

  typedef enum logic {
    MODE_PID  = 1'b0,
    MODE_PROP = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_GAIN_P  = 3'd1,
    REG_GAIN_I  = 3'd2,
    REG_GAIN_D  = 3'd3,
    REG_OUT_MAX = 3'd4,
    REG_OUT_MIN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic [LIM_W-1:0]          out_max;
    logic [LIM_W-1:0]          out_min;
  } cfg_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } calc_res_t;

endpackage

// ----- src/ipid_calc.sv -----
// Combinational control law: gain products, fractional shift, accumulate, clamp, deadband.
module ipid_calc import ipid_pkg::*; (
  input  cfg_t                      cfg,
  input  logic signed [ERR_W-1:0]   err,
  input  logic signed [ERR_W-1:0]   last_err,
  input  logic signed [ERR_W-1:0]   older_err,
  input  logic signed [DRIVE_W-1:0] acc,
  output calc_res_t                 res
);

  logic signed [OP_P_W-1:0]   op_p;
  logic signed [ERR_W-1:0]    op_i;
  logic signed [OP_D_W-1:0]   op_d;
  logic signed [DRIVE_W-1:0]  acc_in;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_shr;
  logic signed [TOT_W-1:0]    total;
  logic signed [TOT_W-1:0]    lim_pos;
  logic signed [TOT_W-1:0]    lim_neg;
  logic signed [DRIVE_W-1:0]  clip;
  logic [DRIVE_W-1:0]         mag;
  logic                       hit;

  always_comb begin
    // Proportional mode reuses the proportional multiplier with the bare
    // error and drops the other terms and the accumulator.
    if (cfg.mode == MODE_PROP) begin
      op_p   = OP_P_W'(err);
      op_i   = '0;
      op_d   = '0;
      acc_in = '0;
    end else begin
      op_p   = OP_P_W'(err) - OP_P_W'(last_err);
      op_i   = err;
      op_d   = OP_D_W'(err) - (OP_D_W'(last_err) <<< 1) + OP_D_W'(older_err);
      acc_in = acc;
    end

    prod_p = cfg.gain_p * op_p;
    prod_i = cfg.gain_i * op_i;
    prod_d = cfg.gain_d * op_d;
    sum    = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    // The arithmetic shift rounds towards minus infinity.
    sum_shr = sum >>> FRAC_W;
    total   = sum_shr[TOT_W-1:0] + TOT_W'(acc_in);

    lim_pos = $signed({{(TOT_W-LIM_W){1'b0}}, cfg.out_max});
    lim_neg = -lim_pos;
    if (total > lim_pos) begin
      clip = lim_pos[DRIVE_W-1:0];
      hit  = 1'b1;
    end else if (total < lim_neg) begin
      clip = lim_neg[DRIVE_W-1:0];
      hit  = 1'b1;
    end else begin
      clip = total[DRIVE_W-1:0];
      hit  = 1'b0;
    end

    mag = clip[DRIVE_W-1] ? DRIVE_W'(-clip) : DRIVE_W'(clip);
    res.clamped = hit;
    if (cfg.mode == MODE_PROP && mag < DRIVE_W'(cfg.out_min)) begin
      res.drive = '0;
    end else begin
      res.drive = clip;
    end
  end

endmodule

// ----- src/incremental_pid_with_p_mode.sv -----
// Top level of the incremental PID controller with a proportional-only mode.
// Each input transaction carries one reference and one feedback sample and produces
// exactly one result transaction: the sample is held in an input register, moves on
// into the result register once that register is free or being emptied, and then
// waits on the outputs for as long as the result is held back. The full control law
// (three gain products, the Q16.16 shift, the accumulator update and the clamp)
// settles combinationally into the result register. A new sample can be taken every
// cycle; the accumulator and error history are updated together with the result
// register, so throughput is one sample per clock as long as results are taken.
// Configuration must only be written while no sample is in flight; the configuration port is always ready.
module incremental_pid_with_p_mode import ipid_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_reference,
  input  logic signed [SAMPLE_W-1:0]  in_feedback,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DRIVE_W-1:0]   out_drive,
  output logic signed [ERR_W-1:0]     out_error_now,
  output logic                        out_clamped,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_data
);

  cfg_t                       cfg_r;
  logic                       in_valid_r;
  logic signed [SAMPLE_W-1:0] ref_r;
  logic signed [SAMPLE_W-1:0] fdb_r;
  logic                       out_valid_r;
  logic signed [DRIVE_W-1:0]  drive_r;
  logic signed [ERR_W-1:0]    err_out_r;
  logic                       clamped_r;
  logic signed [DRIVE_W-1:0]  acc_r;
  logic signed [ERR_W-1:0]    last_err_r;
  logic signed [ERR_W-1:0]    older_err_r;
  logic signed [ERR_W-1:0]    err;
  logic                       advance;
  calc_res_t                  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= MODE_PID;
      cfg_r.gain_p  <= '0;
      cfg_r.gain_i  <= '0;
      cfg_r.gain_d  <= '0;
      cfg_r.out_max <= '1;
      cfg_r.out_min <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:    cfg_r.mode    <= mode_t'(cfg_data[0]);
        REG_GAIN_P:  cfg_r.gain_p  <= $signed(cfg_data);
        REG_GAIN_I:  cfg_r.gain_i  <= $signed(cfg_data);
        REG_GAIN_D:  cfg_r.gain_d  <= $signed(cfg_data);
        REG_OUT_MAX: cfg_r.out_max <= cfg_data[LIM_W-1:0];
        REG_OUT_MIN: cfg_r.out_min <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // The sample in the input register moves on whenever the result register is
  // free or is being emptied in the same cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_drive = drive_r;
  assign out_error_now = err_out_r;
  assign out_clamped   = clamped_r;

  assign err = ERR_W'(ref_r) - ERR_W'(fdb_r);

  ipid_calc u_calc (
    .cfg       (cfg_r),
    .err       (err),
    .last_err  (last_err_r),
    .older_err (older_err_r),
    .acc       (acc_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      last_err_r  <= '0;
      older_err_r <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        acc_r <= res.drive;
        // Proportional mode leaves the error history as it was.
        if (cfg_r.mode == MODE_PID) begin
          older_err_r <= last_err_r;
          last_err_r  <= err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ref_r <= in_reference;
      fdb_r <= in_feedback;
    end
    if (advance) begin
      drive_r   <= res.drive;
      err_out_r <= err;
      clamped_r <= res.clamped;
    end
  end

  // The accumulator always follows the drive that was just issued.
  a_acc_tracks_drive: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (acc_r == drive_r))
    else $error("accumulator does not match issued drive");

  // In PID mode the newest error enters the history alongside its result.
  a_history_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cfg_r.mode == MODE_PID) |=> (last_err_r == err_out_r))
    else $error("error history not updated with the issued error");

  a_history_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cfg_r.mode == MODE_PROP) |=> ($stable(last_err_r) && $stable(older_err_r)))
    else $error("error history changed in proportional mode");

  // Input back-pressure only arises when both stages are full and the output stalls.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

endmodule
